// ----- rtl/utf8s_pkg.sv -----
package utf8s_pkg;

  localparam logic [7:0] FFFD_B0 = 8'hEF;
  localparam logic [7:0] FFFD_B1 = 8'hBF;
  localparam logic [7:0] FFFD_B2 = 8'hBD;

  localparam logic [1:0] CONT_TAG = 2'h2;
  localparam logic [2:0] LEAD2_TAG = 3'h6;
  localparam logic [3:0] LEAD3_TAG = 4'hE;
  localparam logic [4:0] LEAD4_TAG = 5'h1E;

  // output plan of one request: pre fffd, raw bytes, post fffd
  typedef struct packed {
    logic            str_end;
    logic [3:0]      total;
    logic [1:0]      pre;
    logic [1:0]      post;
    logic [2:0]      raw_n;
    logic [3:0][7:0] raw;
  } plan_t;

  function automatic logic [7:0] fffd_byte(input logic [1:0] ph);
    logic [7:0] b;
    case (ph)
      2'd0: b = FFFD_B0;
      2'd1: b = FFFD_B1;
      default: b = FFFD_B2;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/utf8s_decode.sv -----
module utf8s_decode import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output plan_t      plan
);

  logic [7:0]      lead_r, lead_nxt;
  logic [1:0][7:0] cont_r, cont_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [2:0]      len_r, len_nxt;

  logic pending, is_cont, complete;
  logic f_ascii, f_l2, f_l3, f_l4;

  always_comb begin
    pending  = (len_r != 3'd0);
    is_cont  = (in_byte[7:6] == CONT_TAG);
    complete = (({1'b0, held_r} + 3'd2) >= len_r);
    f_ascii  = ~in_byte[7];
    f_l2     = (in_byte[7:5] == LEAD2_TAG);
    f_l3     = (in_byte[7:4] == LEAD3_TAG);
    f_l4     = (in_byte[7:3] == LEAD4_TAG);

    lead_nxt = lead_r;
    cont_nxt = cont_r;
    held_nxt = held_r;
    len_nxt  = len_r;

    plan.str_end = in_end;
    plan.pre     = 2'd0;
    plan.post    = 2'd0;
    plan.raw_n   = 3'd0;
    plan.raw     = '0;

    if (pending && is_cont) begin
      if (complete) begin
        plan.raw_n  = {1'b0, held_r} + 3'd2;
        plan.raw[0] = lead_r;
        plan.raw[1] = (held_r != 2'd0) ? cont_r[0] : in_byte;
        plan.raw[2] = (held_r == 2'd2) ? cont_r[1] : in_byte;
        plan.raw[3] = in_byte;
        len_nxt     = 3'd0;
        held_nxt    = 2'd0;
      end else begin
        cont_nxt[held_r[0]] = in_byte;
        held_nxt            = held_r + 2'd1;
      end
    end else begin
      if (pending) begin
        plan.pre = held_r + 2'd1;
      end
      len_nxt  = 3'd0;
      held_nxt = 2'd0;
      if (f_ascii) begin
        plan.raw_n  = 3'd1;
        plan.raw[0] = in_byte;
      end else if (f_l2) begin
        lead_nxt = in_byte;
        len_nxt  = 3'd2;
      end else if (f_l3) begin
        lead_nxt = in_byte;
        len_nxt  = 3'd3;
      end else if (f_l4) begin
        lead_nxt = in_byte;
        len_nxt  = 3'd4;
      end else begin
        plan.post = 2'd1;
      end
    end

    // end of string flushes whatever is still pending
    if (in_end && (len_nxt != 3'd0)) begin
      plan.post = held_nxt + 2'd1;
      len_nxt   = 3'd0;
      held_nxt  = 2'd0;
    end

    plan.total = ({2'b0, plan.pre} << 1) + {2'b0, plan.pre} + {1'b0, plan.raw_n}
               + ({2'b0, plan.post} << 1) + {2'b0, plan.post};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 8'd0;
      held_r <= 2'd0;
      len_r  <= 3'd0;
    end else if (accept) begin
      lead_r <= lead_nxt;
      held_r <= held_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cont_r <= cont_nxt;
    end
  end

endmodule

// ----- rtl/utf8s_emit.sv -----
module utf8s_emit import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  plan_t      plan,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_end,
  output logic       out_rep
);

  logic [1:0]      pre_r, pre_nxt;
  logic [1:0]      post_r, post_nxt;
  logic [2:0]      rawn_r, rawn_nxt;
  logic [3:0][7:0] raw_r;
  logic [1:0]      idx_r, idx_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [3:0]      rem_r, rem_nxt;
  logic            end_r;

  logic       busy, slot, step;
  logic [7:0] cur_byte;
  logic       cur_rep;

  logic       ovalid_r;
  logic [7:0] obyte_r;
  logic       olast_r, oend_r, orep_r;

  always_comb begin
    busy     = (rem_r != 4'd0);
    slot     = ~ovalid_r | out_ready;
    step     = busy & slot;
    in_ready = ~busy | (slot & (rem_r == 4'd1));

    pre_nxt  = pre_r;
    post_nxt = post_r;
    rawn_nxt = rawn_r;
    idx_nxt  = idx_r;
    ph_nxt   = ph_r;
    rem_nxt  = rem_r;

    if (pre_r != 2'd0) begin
      cur_byte = fffd_byte(ph_r);
      cur_rep  = 1'b1;
      if (ph_r == 2'd2) begin
        ph_nxt  = 2'd0;
        pre_nxt = pre_r - 2'd1;
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end else if (rawn_r != 3'd0) begin
      cur_byte = raw_r[idx_r];
      cur_rep  = 1'b0;
      rawn_nxt = rawn_r - 3'd1;
      idx_nxt  = idx_r + 2'd1;
    end else begin
      cur_byte = fffd_byte(ph_r);
      cur_rep  = 1'b1;
      if (ph_r == 2'd2) begin
        ph_nxt   = 2'd0;
        post_nxt = post_r - 2'd1;
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
    rem_nxt = rem_r - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= 4'd0;
      ovalid_r <= 1'b0;
    end else begin
      if (load) begin
        rem_r <= plan.total;
      end else if (step) begin
        rem_r <= rem_nxt;
      end
      if (slot) begin
        ovalid_r <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pre_r  <= plan.pre;
      post_r <= plan.post;
      rawn_r <= plan.raw_n;
      raw_r  <= plan.raw;
      idx_r  <= 2'd0;
      ph_r   <= 2'd0;
      end_r  <= plan.str_end;
    end else if (step) begin
      pre_r  <= pre_nxt;
      post_r <= post_nxt;
      rawn_r <= rawn_nxt;
      idx_r  <= idx_nxt;
      ph_r   <= ph_nxt;
    end
    if (step) begin
      obyte_r <= cur_byte;
      olast_r <= (rem_r == 4'd1);
      oend_r  <= (rem_r == 4'd1) & end_r;
      orep_r  <= cur_rep;
    end
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_end   = oend_r;
  assign out_rep   = orep_r;

endmodule

// ----- rtl/utf8_sanitizer.sv -----
// the first output byte of a request is loaded into the emitter plan registers
// when the request is accepted, then registered in the output register
// throughput: one request per cycle while each request gives at most one output
// byte and out_tready holds no byte back; a request with more output bytes
// holds off the next one until its last byte is sent, set by the single output byte port
// reset: synchronous active-low rst_n clears pending sequence and output valid
module utf8_sanitizer import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end of string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] run_last, [1] replaced
  output logic       out_tlast   // string_end
);

  plan_t plan;
  logic  accept;
  logic  run_last, replaced;

  assign accept = in_tvalid & in_tready;

  utf8s_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_end  (in_tlast),
    .plan    (plan)
  );

  utf8s_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept & (plan.total != 4'd0)),
    .plan      (plan),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (run_last),
    .out_end   (out_tlast),
    .out_rep   (replaced)
  );

  assign out_tuser = {replaced, run_last};

endmodule
